// ----- hw/rtl/gts_pkg.sv -----
// shared types, constants and latency helper of the geodesic triangle subdivider
// no dependencies
`default_nettype none

package gts_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int CRD_W = 16;          // vertex coordinate width
	localparam int SUM_W = 17;          // edge sum width
	localparam int SQ_W = 33;           // square of an edge sum magnitude
	localparam int N_W = 34;            // squared length of an edge sum
	localparam int MAG_CAP = 32768;     // largest midpoint magnitude
	localparam int NUM_LANES = 9;       // one per edge and coordinate: AB, BC, CA by x, y, z

	typedef logic [1:0] beat_t;
	localparam beat_t BEAT_FIRST = 2'd0;
	localparam beat_t BEAT_LAST = 2'd3;

	typedef struct packed {
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] az;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by_coord;
		logic signed [CRD_W-1:0] bz;
		logic signed [CRD_W-1:0] cx;
		logic signed [CRD_W-1:0] cy;
		logic signed [CRD_W-1:0] cz;
	} triangle_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] p0x;
		logic signed [CRD_W-1:0] p0y;
		logic signed [CRD_W-1:0] p0z;
		logic signed [CRD_W-1:0] p1x;
		logic signed [CRD_W-1:0] p1y;
		logic signed [CRD_W-1:0] p1z;
		logic signed [CRD_W-1:0] p2x;
		logic signed [CRD_W-1:0] p2y;
		logic signed [CRD_W-1:0] p2z;
		logic [1:0]              sub_index;
		logic                    last;
		logic                    degenerate;
	} sub_tri_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} vec_t;

	// corners plus the flag that travel beside the lanes
	typedef struct packed {
		triangle_t corners;
		logic      deg;
	} side_t;

	// registers through one lane: input register, divider, square root, output register
	function automatic int lane_lat(input int f);
		lane_lat = (2 * f + 3) + (f + 2) + 2;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gts_lane.sv -----
// one midpoint component: pipelined restoring divide, then pipelined square root
// depends on gts_pkg
`default_nettype none

module gts_lane import gts_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                     clk,
	input  wire  [SQ_W-1:0]         s_sq,
	input  wire  [N_W-1:0]          n_sum,
	input  wire                     neg,
	input  wire                     zero,
	output logic signed [CRD_W-1:0] mid
);

	localparam int QW = 2 * FRAC_BITS + 3;   // quotient bits
	localparam int SQ = FRAC_BITS + 2;       // root bits
	localparam int RW = SQ + 2;              // root remainder bits

	logic [N_W-1:0] d_rem_s [0:QW];
	logic [QW-1:0]  d_q_s [0:QW];
	logic [N_W-1:0] d_n_s [0:QW-1];
	logic           d_b0_s;
	logic [1:0]     flg_s [0:QW+SQ];          // {neg, zero}

	logic [2*SQ-1:0] t_x_s [1:SQ];
	logic [SQ-1:0]   t_root_s [1:SQ];
	logic [RW-1:0]   t_rem_s [1:SQ];

	logic [SQ:0]        kk;
	logic [CRD_W-1:0]   kmag;

	always_ff @(posedge clk) begin
		d_rem_s[0] <= N_W'(s_sq >> 1);
		d_b0_s <= s_sq[0];
		d_q_s[0] <= '0;
		d_n_s[0] <= n_sum;
		flg_s[0] <= {neg, zero};
	end

	// quotient of s^2 * 2^(2F+2) by n, one bit a stage; only the first bit shifted in can be nonzero
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [N_W:0] sh;
		logic         ge;
		if (j == 0) begin : g_first
			assign sh = {d_rem_s[j], d_b0_s};
		end else begin : g_rest
			assign sh = {d_rem_s[j], 1'b0};
		end
		assign ge = sh >= {1'b0, d_n_s[j]};
		always_ff @(posedge clk) begin
			d_rem_s[j+1] <= ge ? N_W'(sh - {1'b0, d_n_s[j]}) : sh[N_W-1:0];
			d_q_s[j+1] <= {d_q_s[j][QW-2:0], ge};
			flg_s[j+1] <= flg_s[j];
		end
		if (j < QW - 1) begin : g_n
			always_ff @(posedge clk) begin
				d_n_s[j+1] <= d_n_s[j];
			end
		end
	end

	// integer square root of the quotient, two radicand bits a stage
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic [2*SQ-1:0] src_x;
		logic [SQ-1:0]   src_root;
		logic [RW-1:0]   src_rem;
		logic [RW+1:0]   cur;
		logic [RW+1:0]   trial;
		logic            ge;
		if (k == 0) begin : g_first
			assign src_x = {1'b0, d_q_s[QW]};
			assign src_root = '0;
			assign src_rem = '0;
		end else begin : g_rest
			assign src_x = t_x_s[k];
			assign src_root = t_root_s[k];
			assign src_rem = t_rem_s[k];
		end
		assign cur = {src_rem, src_x[2*SQ-1:2*SQ-2]};
		assign trial = (RW+2)'({src_root, 2'b01});
		assign ge = cur >= trial;
		always_ff @(posedge clk) begin
			t_root_s[k+1] <= {src_root[SQ-2:0], ge};
			t_rem_s[k+1] <= ge ? RW'(cur - trial) : cur[RW-1:0];
			t_x_s[k+1] <= src_x << 2;
			flg_s[QW+k+1] <= flg_s[QW+k];
		end
	end

	// largest k with 2k-1 <= root, then sign and saturate, or zero for a zero edge sum
	assign kk = ({1'b0, t_root_s[SQ]} + (SQ+1)'(1)) >> 1;
	assign kmag = CRD_W'(kk);

	always_ff @(posedge clk) begin
		if (flg_s[QW+SQ][0]) begin
			mid <= '0;
		end else if (32'(kk) >= 32'(MAG_CAP)) begin
			mid <= flg_s[QW+SQ][1] ? 16'sh8000 : 16'sh7fff;
		end else begin
			mid <= flg_s[QW+SQ][1] ? -kmag : kmag;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gts_merge.sv -----
// merging stage: holds corners and midpoints, sends four sub-triangle words
// depends on gts_pkg
`default_nettype none

module gts_merge import gts_pkg::*; (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             ld,
	input  side_t                           side,
	input  wire  [NUM_LANES-1:0][CRD_W-1:0] mids,
	output logic                            strobe,
	output sub_tri_t                        sub_tri
);

	side_t                          side_q;
	logic [NUM_LANES-1:0][CRD_W-1:0] mids_q;
	beat_t                          beat_q;
	logic                           active_q;

	vec_t va, vb, vc, mab, mbc, mca, p0, p1, p2;

	always_ff @(posedge clk) begin
		if (ld) begin
			side_q <= side;
			mids_q <= mids;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= BEAT_FIRST;
			active_q <= 1'b0;
		end else if (ld) begin
			beat_q <= BEAT_FIRST;
			active_q <= 1'b1;
		end else if (active_q) begin
			beat_q <= beat_q + 2'd1;
			if (beat_q == BEAT_LAST) begin
				active_q <= 1'b0;
			end
		end
	end

	assign va = '{side_q.corners.ax, side_q.corners.ay, side_q.corners.az};
	assign vb = '{side_q.corners.bx, side_q.corners.by_coord, side_q.corners.bz};
	assign vc = '{side_q.corners.cx, side_q.corners.cy, side_q.corners.cz};
	assign mab = '{mids_q[0], mids_q[1], mids_q[2]};
	assign mbc = '{mids_q[3], mids_q[4], mids_q[5]};
	assign mca = '{mids_q[6], mids_q[7], mids_q[8]};

	always_comb begin
		case (beat_q)
			2'd0: begin
				p0 = va;  p1 = mab; p2 = mca;
			end
			2'd1: begin
				p0 = mab; p1 = vb;  p2 = mbc;
			end
			2'd2: begin
				p0 = mab; p1 = mbc; p2 = mca;
			end
			default: begin
				p0 = mca; p1 = mbc; p2 = vc;
			end
		endcase
	end

	assign strobe = active_q;
	assign sub_tri = '{p0.x, p0.y, p0.z, p1.x, p1.y, p1.z, p2.x, p2.y, p2.z,
		beat_q, beat_q == BEAT_LAST, side_q.deg};

`ifndef NO_ASSERTIONS
	a_load_gap: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> !active_q || beat_q == BEAT_LAST)
		else $error("new word set loaded in the middle of a burst");
	a_burst_runs: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && beat_q != BEAT_LAST |=> active_q)
		else $error("burst ended early");
	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && beat_q == BEAT_LAST && !ld |=> !active_q)
		else $error("burst ran past its last word");
	a_burst_starts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> beat_q == BEAT_FIRST)
		else $error("burst did not start at the first word");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/geodesic_triangle_subdivider.sv -----
// top level of the geodesic triangle subdivider: edge sums, nine lanes, merging stage
// depends on gts_pkg, gts_lane, gts_merge
`default_nettype none

// usage
//   a triangle word (corners A, B, C in signed fixed point) is taken at a rising edge
//   with start high and busy low; busy then stays high while the hold counter runs
//   down, and no new triangle is taken until busy is low again
//   each triangle gives four sub-triangle words on sub_tri, one per cycle with strobe
//   high, in the order (A,mAB,mCA), (mAB,B,mBC), (mAB,mBC,mCA), (mCA,mBC,C); the
//   fourth has last set, and degenerate is set on all four when an edge sum is zero
//   from accept to the first word a triangle passes two front stages for sums and
//   squares, one register into the lanes, 2 * FRAC_BITS + 3 divider stages,
//   FRAC_BITS + 2 square root stages, one lane output register and the merge hold
//   register
//   the triangle rate is bounded by the four words per triangle on the single result
//   port; the lanes themselves take one triangle per cycle
//   nine lanes, one per edge and coordinate, each compute one midpoint component
//   the receiver cannot stall: every word is shown for exactly one cycle
//   reset clears busy and all valid flags; no word comes out until a triangle is taken
module geodesic_triangle_subdivider import gts_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  triangle_t  triangle,
	output logic       strobe,
	output sub_tri_t   sub_tri
);

	localparam int TOT = 2 + lane_lat(FRAC_BITS);   // front stages plus lane

	logic        accept;
	logic [1:0]  hold_q;

	logic signed [CRD_W-1:0] vtx [0:2][0:2];
	logic [SUM_W-1:0] mag_s1 [0:NUM_LANES-1];
	logic             neg_s1 [0:NUM_LANES-1];
	logic             zero_s1 [0:2];
	logic [SQ_W-1:0]  sq_s2 [0:NUM_LANES-1];
	logic             neg_s2 [0:NUM_LANES-1];
	logic             zero_s2 [0:2];
	logic [N_W-1:0]   nsum [0:2];

	logic [NUM_LANES-1:0][CRD_W-1:0] mids;
	side_t side_s [0:TOT-1];
	logic  vld_s [0:TOT-1];

	// a triangle is taken only while busy is low
	assign accept = start && !busy;
	assign busy = hold_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 2'd0;
		end else if (accept) begin
			hold_q <= 2'd3;
		end else if (hold_q != 2'd0) begin
			hold_q <= hold_q - 2'd1;
		end
	end

	assign vtx[0] = '{triangle.ax, triangle.ay, triangle.az};
	assign vtx[1] = '{triangle.bx, triangle.by_coord, triangle.bz};
	assign vtx[2] = '{triangle.cx, triangle.cy, triangle.cz};

	// stage 1: edge sums AB, BC, CA as magnitude and sign
	for (genvar e = 0; e < 3; e++) begin : g_edge
		logic signed [SUM_W-1:0] sum [0:2];
		for (genvar c = 0; c < 3; c++) begin : g_comp
			assign sum[c] = SUM_W'(vtx[e][c]) + SUM_W'(vtx[(e+1)%3][c]);
			always_ff @(posedge clk) begin
				mag_s1[3*e+c] <= sum[c][SUM_W-1] ? SUM_W'(-sum[c]) : SUM_W'(sum[c]);
				neg_s1[3*e+c] <= sum[c][SUM_W-1];
			end
		end
		always_ff @(posedge clk) begin
			zero_s1[e] <= (sum[0] == '0) && (sum[1] == '0) && (sum[2] == '0);
			zero_s2[e] <= zero_s1[e];
		end
		// squared length feeds all three lanes of the edge
		assign nsum[e] = N_W'(sq_s2[3*e]) + N_W'(sq_s2[3*e+1]) + N_W'(sq_s2[3*e+2]);
	end

	// stage 2: squares, then the lanes
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			sq_s2[l] <= SQ_W'(mag_s1[l]) * SQ_W'(mag_s1[l]);
			neg_s2[l] <= neg_s1[l];
		end
		gts_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.s_sq (sq_s2[l]),
			.n_sum(nsum[l/3]),
			.neg  (neg_s2[l]),
			.zero (zero_s2[l/3]),
			.mid  (mids[l])
		);
	end

	// corners and degenerate flag run beside the lanes
	always_ff @(posedge clk) begin
		side_s[0] <= '{triangle, 1'b0};
		side_s[1] <= '{side_s[0].corners, zero_s1[0] || zero_s1[1] || zero_s1[2]};
	end
	for (genvar d = 2; d < TOT; d++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[d] <= side_s[d-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end
	for (genvar d = 1; d < TOT; d++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[d] <= 1'b0;
			end else begin
				vld_s[d] <= vld_s[d-1];
			end
		end
	end

	gts_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (vld_s[TOT-1]),
		.side   (side_s[TOT-1]),
		.mids   (mids),
		.strobe (strobe),
		.sub_tri(sub_tri)
	);

endmodule

`default_nettype wire

// ----- sim/tb_geodesic_triangle_subdivider.sv -----
// testbench of the geodesic triangle subdivider: directed corners, zero edge sums, random words
// depends on gts_pkg and the geodesic_triangle_subdivider rtl
`default_nettype none

module tb_geodesic_triangle_subdivider;
	import gts_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LAT = 3 * FB + 10;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	triangle_t triangle;
	logic      strobe;
	sub_tri_t  sub_tri;

	sub_tri_t  sub_tri_q[$];    // expected sub-triangle words, oldest first
	int        errors = 0;
	bit        quiet_tail = 0;  // no gaps between words near the end

	geodesic_triangle_subdivider dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.triangle(triangle), .strobe(strobe), .sub_tri(sub_tri)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// rounded |s| * 2^FB / sqrt(n): largest k with (2k-1)^2 * n <= s^2 * 2^(2FB+2)
	function automatic int unit_mag(input longint smag, input longint n);
		logic [127:0] rhs, lhs, d;
		int lo, hi, k;
		rhs = (128'(smag) * 128'(smag)) << (2 * FB + 2);
		lo = 0;
		hi = MAG_CAP;
		while (lo < hi) begin
			k = lo + (hi - lo + 1) / 2;
			d = 128'(2 * k - 1);
			lhs = d * d * 128'(n);
			if (lhs <= rhs) lo = k;
			else hi = k - 1;
		end
		return lo;
	endfunction

	// midpoint of p and q pushed back to the unit sphere; zero_sum set when p + q is zero
	function automatic vec_t sphere_mid(input vec_t p, input vec_t q, output bit zero_sum);
		longint s[3];
		longint n;
		int v;
		vec_t m;
		s[0] = longint'(p.x) + longint'(q.x);
		s[1] = longint'(p.y) + longint'(q.y);
		s[2] = longint'(p.z) + longint'(q.z);
		n = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
		zero_sum = (n == 0);
		m = '0;
		if (!zero_sum) begin
			for (int i = 0; i < 3; i++) begin
				v = unit_mag(s[i] < 0 ? -s[i] : s[i], n);
				if (s[i] < 0) v = -v;
				if (v > 32767) v = 32767;
				if (i == 0) m.x = v[15:0];
				else if (i == 1) m.y = v[15:0];
				else m.z = v[15:0];
			end
		end
		return m;
	endfunction

	// four sub-triangles of one input triangle, queued in output order
	function automatic void predict_split(input triangle_t t);
		vec_t a, b, c, mab, mbc, mca;
		vec_t corner[4][3];
		bit z0, z1, z2;
		sub_tri_t w;
		a = '{t.ax, t.ay, t.az};
		b = '{t.bx, t.by_coord, t.bz};
		c = '{t.cx, t.cy, t.cz};
		mab = sphere_mid(a, b, z0);
		mbc = sphere_mid(b, c, z1);
		mca = sphere_mid(c, a, z2);
		corner[0] = '{a, mab, mca};
		corner[1] = '{mab, b, mbc};
		corner[2] = '{mab, mbc, mca};
		corner[3] = '{mca, mbc, c};
		for (int k = 0; k < 4; k++) begin
			w.p0x = corner[k][0].x; w.p0y = corner[k][0].y; w.p0z = corner[k][0].z;
			w.p1x = corner[k][1].x; w.p1y = corner[k][1].y; w.p1z = corner[k][1].z;
			w.p2x = corner[k][2].x; w.p2y = corner[k][2].y; w.p2z = corner[k][2].z;
			w.sub_index = k[1:0];
			w.last = (k == 3);
			w.degenerate = z0 | z1 | z2;
			sub_tri_q.push_back(w);
		end
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endfunction

	// accepted triangles feed the predictor; every strobed word is checked against the oldest
	always @(posedge clk) begin
		sub_tri_t e;
		if (arst_n && start && !busy) predict_split(triangle);
		if (arst_n && strobe) begin
			if (sub_tri_q.size() == 0) begin
				$error("sub_tri: word with nothing expected");
				errors++;
			end else begin
				e = sub_tri_q.pop_front();
				check_field("p0x", e.p0x, sub_tri.p0x);
				check_field("p0y", e.p0y, sub_tri.p0y);
				check_field("p0z", e.p0z, sub_tri.p0z);
				check_field("p1x", e.p1x, sub_tri.p1x);
				check_field("p1y", e.p1y, sub_tri.p1y);
				check_field("p1z", e.p1z, sub_tri.p1z);
				check_field("p2x", e.p2x, sub_tri.p2x);
				check_field("p2y", e.p2y, sub_tri.p2y);
				check_field("p2z", e.p2z, sub_tri.p2z);
				check_field("sub_index", e.sub_index, sub_tri.sub_index);
				check_field("last", e.last, sub_tri.last);
				check_field("degenerate", e.degenerate, sub_tri.degenerate);
			end
		end
	end

	// drive one triangle word and hold it until the block takes it
	task automatic send_triangle(input triangle_t t);
		int gap;
		if (!quiet_tail && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		triangle <= t;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic triangle_t tri_of(input int v[9]);
		triangle_t t;
		t = {v[0][15:0], v[1][15:0], v[2][15:0], v[3][15:0], v[4][15:0],
			v[5][15:0], v[6][15:0], v[7][15:0], v[8][15:0]};
		return t;
	endfunction

	function automatic int coord_rand();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16384 : -16384;
			1: return int'($signed(16'($urandom())));   // off-range noise, all 16 bits
			default: return int'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	// unit axes, poles, extremes of the coordinate range, off-sphere corners
	task automatic test_corners();
		int p = 16384, m = -16384;
		send_triangle(tri_of('{p, 0, 0, 0, p, 0, 0, 0, p}));
		send_triangle(tri_of('{m, 0, 0, 0, m, 0, 0, 0, m}));
		send_triangle(tri_of('{p, p, p, m, m, p, p, m, m}));
		send_triangle(tri_of('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
		send_triangle(tri_of('{32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 1}));
		send_triangle(tri_of('{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 0, 0}));
		send_triangle(tri_of('{-1, -1, -1, -1, -1, -1, 0, 0, -1}));
		send_triangle(tri_of('{21845, -10923, 5461, -21846, 10922, -5462,
			1, -2, 3}));
		send_triangle(tri_of('{9459, 9459, 9459, 9459, -9459, 9459, -9459, 9459, 9459}));
		send_triangle(tri_of('{p, 0, 0, p, 0, 0, p, 0, 0}));
	endtask

	// zero edge sums: opposite corners on each edge, all three at once, and a nearly opposite pair at the range ends
	task automatic test_zero_sum();
		int p = 16384, m = -16384;
		send_triangle(tri_of('{p, 0, 0, m, 0, 0, 0, p, 0}));
		send_triangle(tri_of('{0, p, 0, 0, 0, p, 0, 0, m}));
		send_triangle(tri_of('{100, -200, 300, 0, p, 0, -100, 200, -300}));
		send_triangle(tri_of('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send_triangle(tri_of('{-32768, 0, 0, 32767, 0, 0, 1, 0, 0}));
	endtask

	// random corners, some with an opposite pair to hit zero sums
	task automatic test_random(input int count);
		int v[9];
		int e;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) v[i] = coord_rand();
			if ($urandom_range(0, 9) == 0) begin
				e = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) v[((e + 1) % 3) * 3 + i] = -v[e * 3 + i];
			end
			send_triangle(tri_of(v));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		triangle = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corners();
		test_zero_sum();
		test_random(400);
		quiet_tail = 1;
		test_random(80);
		start <= 1'b0;
		while (sub_tri_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// hard limit on the whole run
	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/gts_pkg.sv
hw/rtl/gts_lane.sv
hw/rtl/gts_merge.sv
hw/rtl/geodesic_triangle_subdivider.sv
sim/tb_geodesic_triangle_subdivider.sv
